@@ hw/rtl/wat_pkg.sv @@
// ----------------------------------------------------------------------------
// Weekly alarm table package
// Types and constants shared by the alarm table top level and its helpers.
// ----------------------------------------------------------------------------
package wat_pkg;

    localparam int MIN_PER_HOUR    = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int MIN_PER_DAY     = MIN_PER_HOUR * HOURS_PER_DAY;
    localparam int DAYS_PER_WEEK   = 7;
    localparam int MIN_PER_WEEK    = MIN_PER_DAY * DAYS_PER_WEEK;
    localparam int NO_NEXT_MINUTES = 1;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int MINUTES_W  = 14;
    localparam int DUR_W      = 11;
    localparam int TOD_W      = 12;

    // Request kinds carried on tuser.
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_MATCH   = 2'd2,
        KIND_NEAREST = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One stored alarm.
    typedef struct packed {
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [6:0]       mask;
        logic             active;
        logic [DUR_W-1:0] duration;
    } alarm_t;

    // Query context held for the length of a scan.
    typedef struct packed {
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [2:0]       weekday;
        logic [TOD_W-1:0] now;
    } query_t;

    // Result of checking one alarm against the query.
    typedef struct packed {
        logic                 match_hit;
        logic                 near_hit;
        logic [MINUTES_W-1:0] near_diff;
    } eval_t;

endpackage

@@ hw/rtl/weekly_alarm_table.sv @@
// ----------------------------------------------------------------------------
// Weekly alarm table
// Indexed table of weekly alarms with write, remove, match and nearest requests.
// ----------------------------------------------------------------------------
// The block keeps ENTRIES alarms in a single-port-read memory, each with hour,
// minute, weekday mask, active flag and duration, plus one valid flip-flop per
// entry that reset clears. Every request returns exactly one result. For write
// and remove requests the table is updated at acceptance; the finish state
// then loads the result into the output register once that register is free.
// Match and nearest requests walk the table one entry per cycle through the
// memory's only read port, then post their result the same way from the finish
// state. One request is in flight at a time; a new request is taken as
// soon as the previous result sits in the output register, even if the
// downstream side has not yet taken it. Since the table is only written at
// acceptance and scanned afterwards, a read never overlaps a write to the
// same entry. Entries that were never written are never reported, because
// their valid bit stays low. A match result carries the duration of the
// lowest-indexed valid, active alarm that fires at the given time and
// weekday; a nearest result carries the minutes to the next occurrence of any
// valid alarm over the coming seven days, or 1 with next_found low.
// ----------------------------------------------------------------------------
module weekly_alarm_table #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata, lowest bit up: entry_index(4), alarm_hour(5), alarm_minute(6),
    // day_mask(7), alarm_active(1), alarm_duration(11), query_hour(5),
    // query_minute(6), query_weekday(3)
    input  logic [47:0] s_tdata,
    // tuser: kind(2)
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, lowest bit up: op_ok(1), match_duration(11), minutes_to_next(14),
    // next_found(1), zero fill(5)
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    wat_pkg::kind_t  in_kind;
    logic [3:0]      in_index;
    wat_pkg::alarm_t in_alarm;
    wat_pkg::query_t in_query;
    logic            in_range;
    logic [ADDR_W-1:0] in_addr;
    logic            accept;

    assign in_kind         = wat_pkg::kind_t'(s_tuser);
    assign in_index        = s_tdata[3:0];
    assign in_alarm.hour     = s_tdata[8:4];
    assign in_alarm.minute   = s_tdata[14:9];
    assign in_alarm.mask     = s_tdata[21:15];
    assign in_alarm.active   = s_tdata[22];
    assign in_alarm.duration = s_tdata[33:23];
    assign in_query.hour     = s_tdata[38:34];
    assign in_query.minute   = s_tdata[44:39];
    assign in_query.weekday  = s_tdata[47:45];
    assign in_query.now      = 12'(s_tdata[38:34]) * 12'(wat_pkg::MIN_PER_HOUR)
                             + 12'(s_tdata[44:39]);

    // Indexes past the table are ignored and report failure.
    assign in_range = int'(in_index) < ENTRIES;
    assign in_addr  = ADDR_W'(in_index);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    wat_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pv_reg, pv_next;       // a read is returning this cycle
    logic                 pvld_reg, pvld_next;   // valid bit of that entry
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    wat_pkg::kind_t       kind_reg, kind_next;
    wat_pkg::query_t      query_reg, query_next;
    logic                 ok_reg, ok_next;
    logic [wat_pkg::DUR_W-1:0]     dur_reg, dur_next;
    logic                 mhit_reg, mhit_next;
    logic [wat_pkg::MINUTES_W-1:0] best_reg, best_next;
    logic                 found_reg, found_next;

    // ------------------------------------------------------------------
    // Table memory and entry evaluation
    // ------------------------------------------------------------------
    logic                        ram_wr_en;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [$bits(wat_pkg::alarm_t)-1:0] ram_rd_data;
    wat_pkg::alarm_t             rd_alarm;
    wat_pkg::eval_t              eval;

    assign ram_wr_en = accept && (in_kind == wat_pkg::KIND_WRITE) && in_range;
    assign rd_addr   = cnt_reg[ADDR_W-1:0];
    assign rd_alarm  = wat_pkg::alarm_t'(ram_rd_data);

    wat_ram #(
        .WIDTH ($bits(wat_pkg::alarm_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_addr),
        .wr_data (in_alarm),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    wat_entry_eval u_eval (
        .entry  (rd_alarm),
        .query  (query_reg),
        .result (eval)
    );

    // ------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------
    logic scan_last;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wat_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_kind == wat_pkg::KIND_MATCH || in_kind == wat_pkg::KIND_NEAREST) begin
                        state_next = wat_pkg::ST_SCAN;
                    end else begin
                        state_next = wat_pkg::ST_FINISH;
                    end
                end
            end
            wat_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = wat_pkg::ST_FINISH;
                end
            end
            wat_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = wat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wat_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control: outputs of the state machine
    // ------------------------------------------------------------------
    logic load_out;

    always_comb begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        scan_last = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            wat_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            wat_pkg::ST_SCAN: begin
                // The last entry's data returns in the cycle the counter
                // reaches the table size.
                rd_en     = (cnt_reg != CNT_W'(ENTRIES));
                scan_last = (cnt_reg == CNT_W'(ENTRIES));
            end
            wat_pkg::ST_FINISH: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        cnt_next   = cnt_reg;
        pv_next    = rd_en;
        pvld_next  = rd_en ? valid_reg[rd_addr] : 1'b0;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        query_next = query_reg;
        ok_next    = ok_reg;
        dur_next   = dur_reg;
        mhit_next  = mhit_reg;
        best_next  = best_reg;
        found_next = found_reg;

        if (accept) begin
            kind_next  = in_kind;
            query_next = in_query;
            cnt_next   = '0;
            ok_next    = 1'b0;
            dur_next   = '0;
            mhit_next  = 1'b0;
            best_next  = wat_pkg::MINUTES_W'(wat_pkg::MIN_PER_WEEK);
            found_next = 1'b0;
            if (in_kind == wat_pkg::KIND_WRITE && in_range) begin
                valid_next[in_addr] = 1'b1;
                ok_next             = 1'b1;
            end else if (in_kind == wat_pkg::KIND_REMOVE && in_range) begin
                ok_next             = valid_reg[in_addr];
                valid_next[in_addr] = 1'b0;
            end
        end

        if (rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // Fold in the entry whose data the memory returns this cycle.
        if (pv_reg && pvld_reg) begin
            if (kind_reg == wat_pkg::KIND_MATCH && eval.match_hit && !mhit_reg) begin
                mhit_next = 1'b1;
                dur_next  = rd_alarm.duration;
            end
            if (kind_reg == wat_pkg::KIND_NEAREST && eval.near_hit
                && eval.near_diff < best_reg) begin
                best_next  = eval.near_diff;
                found_next = 1'b1;
            end
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[0]     = ok_reg;
            m_tdata_next[11:1]  = dur_reg;
            m_tdata_next[25:12] = (kind_reg != wat_pkg::KIND_NEAREST) ? '0
                                : found_reg ? best_reg
                                : wat_pkg::MINUTES_W'(wat_pkg::NO_NEXT_MINUTES);
            m_tdata_next[26]    = found_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wat_pkg::ST_IDLE;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pv_reg       <= pv_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pvld_reg    <= pvld_next;
        kind_reg    <= kind_next;
        query_reg   <= query_next;
        ok_reg      <= ok_next;
        dur_reg     <= dur_next;
        mhit_reg    <= mhit_next;
        best_reg    <= best_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A result appears only after the request reached its final state.
    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == wat_pkg::ST_FINISH))
        else $error("result posted outside the finish state");

    // The scan counter never runs past the table.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wat_pkg::ST_SCAN) |-> (int'(cnt_reg) <= ENTRIES))
        else $error("scan counter beyond table size");

    // A found occurrence always lies within one week.
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wat_pkg::ST_FINISH && found_reg)
        |-> (int'(best_reg) < wat_pkg::MIN_PER_WEEK))
        else $error("nearest distance out of range");

    // A write to a slot in the table leaves that slot valid.
    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> valid_reg[$past(in_addr)])
        else $error("written entry not marked valid");

endmodule

@@ hw/rtl/wat_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wat_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/wat_entry_eval.sv @@
// ----------------------------------------------------------------------------
// Alarm entry evaluator
// Checks one stored alarm against a match query and a nearest query.
// ----------------------------------------------------------------------------
module wat_entry_eval (
    input  wat_pkg::alarm_t entry,
    input  wat_pkg::query_t query,
    output wat_pkg::eval_t  result
);

    localparam int DAYS = wat_pkg::DAYS_PER_WEEK;

    logic [wat_pkg::TOD_W-1:0] alarm_tod;
    logic signed [15:0]        rel;
    logic signed [15:0]        diff [DAYS];
    logic [DAYS-1:0]           rot_mask;
    logic [2:0]                rot_base;

    always_comb begin
        logic [3:0] day_sum;
        logic [3:0] day_idx;
        alarm_tod = 12'(entry.hour) * 12'(wat_pkg::MIN_PER_HOUR) + 12'(entry.minute);
        rel       = signed'(16'(alarm_tod)) - signed'(16'(query.now));
        // A weekday of seven behaves as weekday zero in the day rotation.
        rot_base  = (query.weekday == 3'd7) ? 3'd0 : query.weekday;
        for (int o = 0; o < DAYS; o++) begin
            day_sum     = 4'(rot_base) + 4'(o);
            day_idx     = (day_sum >= 4'(DAYS)) ? day_sum - 4'(DAYS) : day_sum;
            rot_mask[o] = entry.mask[day_idx[2:0]];
            diff[o]     = rel + signed'(16'(o * wat_pkg::MIN_PER_DAY));
        end
    end

    // The distance grows with the day offset, so the first usable offset wins.
    always_comb begin
        result.near_hit  = 1'b0;
        result.near_diff = '0;
        for (int o = DAYS - 1; o >= 0; o--) begin
            if (rot_mask[o] && !diff[o][15]) begin
                result.near_hit  = 1'b1;
                result.near_diff = diff[o][wat_pkg::MINUTES_W-1:0];
            end
        end
        result.match_hit = entry.active
                        && (entry.hour == query.hour)
                        && (entry.minute == query.minute)
                        && (query.weekday != 3'd7)
                        && entry.mask[query.weekday];
    end

endmodule

@@ test/weekly_alarm_table_tb.sv @@
// ----------------------------------------------------------------------------
// Weekly alarm table testbench
// Drives write, remove, match and nearest requests into the alarm table and
// checks every result against a scoreboard that keeps its own copy of the
// table, under bursty input traffic and a stalling result channel.
// ----------------------------------------------------------------------------
module weekly_alarm_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE    = 16;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int FIRST_HOLD_AT = 150;
    localparam int LAST_HOLD_AT  = 350;
    localparam int SETTLE_CYCLES = 40;

    // One result as the block reports it.
    typedef struct {
        logic                          op_ok;
        logic [wat_pkg::DUR_W-1:0]     match_duration;
        logic [wat_pkg::MINUTES_W-1:0] minutes_to_next;
        logic                          next_found;
    } alarm_result_t;

    // Behaviors of the result side; each one lasts for a random stretch.
    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } ready_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the alarm table plus the results still owed.
    // ------------------------------------------------------------------------
    class alarm_scoreboard;
        wat_pkg::alarm_t slots [TABLE_SIZE];
        bit              valid [TABLE_SIZE];
        alarm_result_t   owed_results [$];
        int              errors;

        // Duration of the lowest-indexed enabled alarm firing at this time.
        function logic [wat_pkg::DUR_W-1:0] firing_duration(logic [4:0] qh,
                                                            logic [5:0] qm,
                                                            logic [2:0] wd);
            if (wd >= wat_pkg::DAYS_PER_WEEK)
                return '0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (valid[i] && slots[i].active && slots[i].hour == qh &&
                    slots[i].minute == qm && slots[i].mask[wd])
                    return slots[i].duration;
            end
            return '0;
        endfunction

        // Minutes to the next occurrence of any stored alarm, enabled or not.
        // A weekday of seven simply wraps like weekday zero.
        function void next_occurrence(input logic [4:0] qh, input logic [5:0] qm,
                                      input logic [2:0] wd, output int mins,
                                      output bit found);
            int now_min;
            int at_min;
            int diff;
            int best;
            now_min = int'(qh) * wat_pkg::MIN_PER_HOUR + int'(qm);
            best    = wat_pkg::MIN_PER_WEEK;
            found   = 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (!valid[i])
                    continue;
                at_min = int'(slots[i].hour) * wat_pkg::MIN_PER_HOUR
                       + int'(slots[i].minute);
                for (int o = 0; o < wat_pkg::DAYS_PER_WEEK; o++) begin
                    if (!slots[i].mask[(int'(wd) + o) % wat_pkg::DAYS_PER_WEEK])
                        continue;
                    diff = o * wat_pkg::MIN_PER_DAY + at_min - now_min;
                    if (diff >= 0 && diff < best) begin
                        best  = diff;
                        found = 1'b1;
                    end
                end
            end
            mins = found ? best : wat_pkg::NO_NEXT_MINUTES;
        endfunction

        // Called for every request the block accepts, in acceptance order.
        function void note_request(wat_pkg::kind_t kind,
                                   logic [wat_pkg::IN_DATA_W-1:0] d);
            alarm_result_t r;
            logic [3:0]    idx;
            int            mins;
            bit            found;
            idx = d[3:0];
            r   = '{op_ok: 1'b0, match_duration: '0, minutes_to_next: '0,
                    next_found: 1'b0};
            unique case (kind)
                wat_pkg::KIND_WRITE: begin
                    slots[idx] = '{hour: d[8:4], minute: d[14:9], mask: d[21:15],
                                   active: d[22], duration: d[33:23]};
                    valid[idx] = 1'b1;
                    r.op_ok    = 1'b1;
                end
                wat_pkg::KIND_REMOVE: begin
                    r.op_ok    = valid[idx];
                    valid[idx] = 1'b0;
                end
                wat_pkg::KIND_MATCH: begin
                    r.match_duration = firing_duration(d[38:34], d[44:39], d[47:45]);
                end
                default: begin
                    next_occurrence(d[38:34], d[44:39], d[47:45], mins, found);
                    r.minutes_to_next = wat_pkg::MINUTES_W'(mins);
                    r.next_found      = found;
                end
            endcase
            owed_results.push_back(r);
        endfunction

        // Called for every result the block hands over.
        function void check_result(logic [wat_pkg::OUT_DATA_W-1:0] t);
            alarm_result_t e;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h with no request outstanding", $time, t);
                return;
            end
            e = owed_results.pop_front();
            if (t[0] !== e.op_ok || t[11:1] !== e.match_duration ||
                t[25:12] !== e.minutes_to_next || t[26] !== e.next_found) begin
                errors++;
                $display("%0t: result differs: expected ok=%0d dur=%0d mins=%0d found=%0d",
                         $time, e.op_ok, e.match_duration, e.minutes_to_next,
                         e.next_found);
                $display("%0t:                 actual   ok=%0d dur=%0d mins=%0d found=%0d",
                         $time, t[0], t[11:1], t[25:12], t[26]);
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the device under test.
    // ------------------------------------------------------------------------
    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic [wat_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [wat_pkg::IN_USER_W-1:0]  s_tuser  = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [wat_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    alarm_scoreboard sb = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    weekly_alarm_table #(.ENTRIES(TABLE_SIZE)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Hard stop in case the block hangs; reaching it counts as a failure.
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("weekly_alarm_table: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Every accepted result is checked at the edge that takes
    // it. Readiness follows a random behavior for a random stretch, and twice
    // the side holds off for a long run of cycles so that the output register
    // fills, the block stops taking requests and the sender sits blocked.
    // ------------------------------------------------------------------------
    ready_mode_t ready_mode   = RDY_ALWAYS;
    int unsigned stretch_left = 0;
    int unsigned hold_left    = 0;
    int unsigned results_seen = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                results_seen++;
                if (results_seen == FIRST_HOLD_AT || results_seen == LAST_HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(10, 120);
                    ready_mode   = ready_mode_t'($urandom_range(0, 4));
                end else begin
                    stretch_left--;
                end
                unique case (ready_mode)
                    RDY_ALWAYS:   m_tready <= 1'b1;
                    RDY_HALF:     m_tready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:      m_tready <= (cycle_count % 5) >= 2;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Fields packed from the lowest bit up as the tdata port lists them.
    function automatic logic [wat_pkg::IN_DATA_W-1:0] pack_request(
        logic [3:0] idx, logic [4:0] ah, logic [5:0] am, logic [6:0] mask,
        logic act, logic [wat_pkg::DUR_W-1:0] dur, logic [4:0] qh, logic [5:0] qm,
        logic [2:0] wd);
        return {wd, qm, qh, dur, act, mask, am, ah, idx};
    endfunction

    // Offers one request and returns at the edge that accepts it. The caller
    // is always at a rising edge, so a back-to-back request keeps tvalid high.
    task automatic send_request(wat_pkg::kind_t kind, logic [wat_pkg::IN_DATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(kind, d);
    endtask

    // Fields that a request kind ignores are filled with random bits.
    task automatic write_alarm(logic [3:0] idx, logic [4:0] ah, logic [5:0] am,
                               logic [6:0] mask, logic act,
                               logic [wat_pkg::DUR_W-1:0] dur);
        send_request(wat_pkg::KIND_WRITE, pack_request(idx, ah, am, mask, act, dur,
                     5'($urandom()), 6'($urandom()), 3'($urandom())));
    endtask

    task automatic remove_alarm(logic [3:0] idx);
        send_request(wat_pkg::KIND_REMOVE, pack_request(idx, 5'($urandom()),
                     6'($urandom()), 7'($urandom()), 1'($urandom()),
                     wat_pkg::DUR_W'($urandom()), 5'($urandom()), 6'($urandom()),
                     3'($urandom())));
    endtask

    task automatic ask(wat_pkg::kind_t kind, logic [4:0] qh, logic [5:0] qm,
                       logic [2:0] wd);
        send_request(kind, pack_request(4'($urandom()), 5'($urandom()), 6'($urandom()),
                     7'($urandom()), 1'($urandom()), wat_pkg::DUR_W'($urandom()),
                     qh, qm, wd));
    endtask

    // Drops tvalid and waits until the block owes nothing.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    // Mostly legal clock values, with the out-of-range codes now and then.
    function automatic logic [4:0] rand_hour();
        return 5'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 23)
                                              : $urandom_range(24, 31));
    endfunction

    function automatic logic [5:0] rand_minute();
        return 6'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 59)
                                              : $urandom_range(60, 63));
    endfunction

    function automatic logic [2:0] rand_weekday();
        return ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 6)) : 3'd7;
    endfunction

    // One random request. Writes and removes crowd onto a few low slots so
    // that overwrites and removes of live entries are common; most queries
    // aim at the time of a stored alarm so that matches actually happen.
    task automatic send_random_request();
        int          pick;
        int          src;
        logic [3:0]  idx;
        logic [4:0]  qh;
        logic [5:0]  qm;
        logic [2:0]  wd;
        logic [6:0]  mask;
        logic [wat_pkg::DUR_W-1:0] dur;
        pick = $urandom_range(0, 99);
        idx  = 4'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 5)
                                              : $urandom_range(0, 15));
        if (pick < 30) begin
            mask = 7'(($urandom_range(0, 3) == 0) ? (7'd1 << $urandom_range(0, 6))
                                                  : $urandom_range(0, 127));
            dur  = wat_pkg::DUR_W'(($urandom_range(0, 6) != 0)
                                   ? $urandom_range(0, wat_pkg::MIN_PER_DAY)
                                   : $urandom_range(wat_pkg::MIN_PER_DAY + 1, 2047));
            write_alarm(idx, rand_hour(), rand_minute(), mask,
                        $urandom_range(0, 3) != 0, dur);
        end else if (pick < 45) begin
            remove_alarm(idx);
        end else begin
            src = $urandom_range(0, TABLE_SIZE - 1);
            qh  = rand_hour();
            qm  = rand_minute();
            wd  = rand_weekday();
            if (sb.valid[src] && $urandom_range(0, 4) < 3) begin
                qh = sb.slots[src].hour;
                qm = sb.slots[src].minute;
                if (sb.slots[src].mask != 0 && $urandom_range(0, 3) != 0) begin
                    do
                        wd = 3'($urandom_range(0, 6));
                    while (!sb.slots[src].mask[wd]);
                end
            end
            ask((pick < 75) ? wat_pkg::KIND_MATCH : wat_pkg::KIND_NEAREST, qh, qm, wd);
        end
    endtask

    initial begin : stimulus
        int  sent;
        int  burst;
        int  gap;
        bit  paused_midway;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. An empty table first: nothing matches, nothing is
        // next, and removing a slot that was never written reports failure.
        ask(wat_pkg::KIND_NEAREST, 5'd12, 6'd0, 3'd2);
        ask(wat_pkg::KIND_MATCH, 5'd0, 6'd0, 3'd0);
        remove_alarm(4'd3);

        // Extreme slots, times, masks and durations. Slots 0 and 1 share a
        // time, but only slot 0's mask holds weekday three, so slot 0 alone matches.
        write_alarm(4'd0, 5'd6, 6'd30, 7'h7F, 1'b1, 11'd1440);
        write_alarm(4'd15, 5'd23, 6'd59, 7'h01, 1'b0, 11'd2047);
        write_alarm(4'd7, 5'd0, 6'd0, 7'h00, 1'b1, 11'd0);
        write_alarm(4'd1, 5'd6, 6'd30, 7'h20, 1'b1, 11'd5);
        ask(wat_pkg::KIND_MATCH, 5'd6, 6'd30, 3'd3);
        // Weekday seven has no mask bit, so the match finds nothing.
        ask(wat_pkg::KIND_MATCH, 5'd6, 6'd30, 3'd7);
        // A disabled alarm never matches but still counts as the next one.
        ask(wat_pkg::KIND_MATCH, 5'd23, 6'd59, 3'd0);
        ask(wat_pkg::KIND_NEAREST, 5'd6, 6'd31, 3'd0);
        ask(wat_pkg::KIND_NEAREST, 5'd23, 6'd59, 3'd6);
        // Weekday seven on a nearest request wraps like weekday zero.
        ask(wat_pkg::KIND_NEAREST, 5'd0, 6'd0, 3'd7);

        // Out-of-range hour and minute are stored and compared as plain numbers.
        write_alarm(4'd2, 5'd31, 6'd63, 7'h7F, 1'b1, 11'd1000);
        ask(wat_pkg::KIND_MATCH, 5'd31, 6'd63, 3'd6);
        ask(wat_pkg::KIND_NEAREST, 5'd31, 6'd63, 3'd5);

        // Remove a live slot, then the same slot again, and let slot 1 win.
        remove_alarm(4'd0);
        remove_alarm(4'd0);
        ask(wat_pkg::KIND_MATCH, 5'd6, 6'd30, 3'd5);
        remove_alarm(4'd1);
        remove_alarm(4'd2);
        remove_alarm(4'd7);
        remove_alarm(4'd15);
        ask(wat_pkg::KIND_NEAREST, 5'd6, 6'd30, 3'd1);

        wait_for_drain();

        // Random part in bursts with gaps long enough to land on any cycle of
        // a table scan. Halfway through, the sender waits out every result.
        sent          = 0;
        paused_midway = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
                send_random_request();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (!paused_midway && sent >= RANDOM_ITEMS / 2) begin
                paused_midway = 1'b1;
                wait_for_drain();
            end else if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        wait_for_drain();
        // Any stray result after the last one owed would show up here.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("weekly_alarm_table: match");
        else
            $display("weekly_alarm_table: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/wat_pkg.sv
hw/rtl/wat_ram.sv
hw/rtl/wat_entry_eval.sv
hw/rtl/weekly_alarm_table.sv
test/weekly_alarm_table_tb.sv
